// ----- design/bst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, character constants and the lexer step table of the byte
// stream tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

    // Lexer states.
    typedef enum logic [2:0] {
        ST_INIT = 3'd0,
        ST_COMM = 3'd1,
        ST_NUM  = 3'd2,
        ST_FLT  = 3'd3,
        ST_NAME = 3'd4,
        ST_OP   = 3'd5,
        ST_CMP  = 3'd6
    } t_lex_state;

    // Byte classes.
    typedef enum logic [3:0] {
        CL_DIGIT = 4'd0,
        CL_ALPHA = 4'd1,
        CL_DOT   = 4'd2,
        CL_OP    = 4'd3,
        CL_CMP   = 4'd4,
        CL_EQ    = 4'd5,
        CL_HASH  = 4'd6,
        CL_NL    = 4'd7,
        CL_SP    = 4'd8
    } t_char_class;

    // Token kinds as they appear on the output.
    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_FLT  = 2'd1;
    localparam logic [1:0] KIND_NAME = 2'd2;
    localparam logic [1:0] KIND_OP   = 2'd3;

    localparam logic [7:0] C_NEWLINE = 8'h0A;
    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_ZERO    = 8'h30;
    localparam logic [15:0] POS_MAX  = 16'hFFFF;

    // One step of the state table: either a next state or no transition.
    typedef struct packed {
        logic       none;
        t_lex_state nxt;
    } t_step;

    // Token description handed from the lexer to the emitter.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] int_value;
        logic [29:0] frac_digits;
        logic [3:0]  frac_count;
        logic [15:0] start_line;
        logic [15:0] start_column;
    } t_tok_info;

    function automatic t_char_class f_classify(logic [7:0] c);
        t_char_class cls;
        cls = CL_ALPHA;
        if (c == " " || c == C_TAB) begin
            cls = CL_SP;
        end else if (c >= "0" && c <= "9") begin
            cls = CL_DIGIT;
        end else begin
            case (c)
                ",", ";", "'", "+", "-", "*", "/",
                "(", ")", "[", "]", "&", "|": cls = CL_OP;
                "<", ">", "!":                 cls = CL_CMP;
                "=":                           cls = CL_EQ;
                ".":                           cls = CL_DOT;
                "#":                           cls = CL_HASH;
                C_NEWLINE:                     cls = CL_NL;
                default:                       cls = CL_ALPHA;
            endcase
        end
        return cls;
    endfunction

    function automatic t_step f_step(t_lex_state s, t_char_class c);
        t_step r;
        r.none = 1'b0;
        r.nxt  = ST_INIT;
        unique case (s)
            ST_INIT: begin
                unique case (c)
                    CL_DIGIT:     r.nxt = ST_NUM;
                    CL_ALPHA:     r.nxt = ST_NAME;
                    CL_DOT:       r.nxt = ST_FLT;
                    CL_OP:        r.nxt = ST_OP;
                    CL_CMP:       r.nxt = ST_CMP;
                    CL_EQ:        r.nxt = ST_CMP;
                    CL_HASH:      r.nxt = ST_COMM;
                    default:      r.nxt = ST_INIT;
                endcase
            end
            ST_COMM: r.nxt = (c == CL_NL) ? ST_INIT : ST_COMM;
            ST_NUM: begin
                if (c == CL_DIGIT) begin
                    r.nxt = ST_NUM;
                end else if (c == CL_DOT) begin
                    r.nxt = ST_FLT;
                end else begin
                    r.none = 1'b1;
                end
            end
            ST_FLT: begin
                if (c == CL_DIGIT) r.nxt = ST_FLT;
                else r.none = 1'b1;
            end
            ST_NAME: begin
                if (c == CL_DIGIT || c == CL_ALPHA) r.nxt = ST_NAME;
                else r.none = 1'b1;
            end
            ST_OP: r.none = 1'b1;
            ST_CMP: begin
                if (c == CL_EQ) r.nxt = ST_CMP;
                else r.none = 1'b1;
            end
            default: r.none = 1'b1;
        endcase
        return r;
    endfunction

endpackage

// ----- design/bst_text_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_text_ram
// Text byte store: rows of eight bytes, one byte lane written per cycle,
// one full row read per cycle with registered read data.
// ----------------------------------------------------------------------------
module bst_text_ram #(
    parameter int AW = 3
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [2:0]    i_wr_lane,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [63:0]   o_rd_data
);

    logic [7:0][7:0] r_mem [2**AW];
    logic [63:0]     r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][i_wr_lane] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/bst_lexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_lexer
// Byte classification, state table step, number accumulation, position
// tracking and text writes into the text store.
// ----------------------------------------------------------------------------
module bst_lexer #(
    parameter int MAX_TEXT        = 32,
    parameter int MAX_FRAC_DIGITS = 9,
    localparam int CW   = $clog2(MAX_TEXT + 1),
    localparam int FCW  = $clog2(MAX_FRAC_DIGITS + 1),
    localparam int ROWS = (MAX_TEXT + 7) / 8,
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int AW   = RW + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_char_code,
    input  logic                i_end_of_input,
    input  logic                i_busy,
    output logic                o_stall,
    output logic                o_desc_valid,
    output bst_pkg::t_tok_info  o_desc,
    output logic [CW-1:0]       o_desc_count,
    output logic                o_desc_bank,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [2:0]          o_wr_lane,
    output logic [7:0]          o_wr_data
);
    import bst_pkg::*;

    t_lex_state       r_state, n_state;
    logic [31:0]      r_int, n_int;
    logic [29:0]      r_frac, n_frac;
    logic [FCW-1:0]   r_fc, n_fc;
    logic [CW-1:0]    r_count, n_count;
    logic [15:0]      r_line, n_line;
    logic [15:0]      r_col, n_col;
    logic [15:0]      r_tline, n_tline;
    logic [15:0]      r_tcol, n_tcol;
    logic             r_bank, n_bank;

    t_char_class      w_cls;
    t_step            w_cur, w_nxt;
    t_lex_state       w_eff;
    logic             w_accept;
    logic             w_byte;
    logic [3:0]       w_digit;
    logic [CW-1:0]    w_app_idx;
    logic [CW-1:0]    w_app_row;
    logic [FCW+3:0]   w_fc_ext;
    logic             w_numeric;

    assign w_cls    = f_classify(i_char_code);
    assign w_cur    = f_step(r_state, w_cls);
    assign w_eff    = w_cur.none ? ST_INIT : r_state;
    assign w_nxt    = f_step(w_eff, w_cls);
    assign w_digit  = 4'(i_char_code - C_ZERO);

    // A byte that closes a token needs the emitter slot; everything else flows.
    assign o_stall  = i_valid && !i_end_of_input && w_cur.none && i_busy;
    assign w_accept = i_valid && !o_stall;
    assign w_byte   = w_accept && !i_end_of_input;

    // A new token's text always starts at index zero; numeric tokens write no text.
    assign w_app_idx = (w_eff == ST_INIT) ? '0 : r_count;
    assign w_app_row = w_app_idx >> 3;

    // Next state.
    always_comb begin
        n_state = r_state;
        if (w_accept) begin
            if (i_end_of_input || w_nxt.none) n_state = ST_INIT;
            else n_state = w_nxt.nxt;
        end
    end

    // Datapath and text writes.
    always_comb begin
        n_int   = r_int;
        n_frac  = r_frac;
        n_fc    = r_fc;
        n_count = r_count;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_bank  = r_bank;
        o_wr_en = 1'b0;
        if (w_accept && i_end_of_input) begin
            n_count = '0;
        end else if (w_byte) begin
            if (w_cls == CL_NL) begin
                if (r_line < POS_MAX) n_line = r_line + 16'd1;
                n_col = '0;
            end else if (r_col < POS_MAX) begin
                n_col = r_col + 16'd1;
            end
            if (w_cur.none) n_bank = ~r_bank;
            unique case (w_eff)
                ST_INIT: begin
                    if (w_cls == CL_DIGIT) begin
                        n_int   = {28'd0, w_digit};
                        n_tline = n_line;
                        n_tcol  = n_col;
                    end else if (w_cls == CL_ALPHA || w_cls == CL_OP ||
                                 w_cls == CL_CMP || w_cls == CL_EQ) begin
                        o_wr_en = 1'b1;
                        n_count = w_app_idx + 1'b1;
                        n_tline = n_line;
                        n_tcol  = n_col;
                    end else if (w_cls == CL_DOT) begin
                        n_int   = '0;
                        n_frac  = '0;
                        n_fc    = '0;
                        n_tline = n_line;
                        n_tcol  = n_col;
                    end
                end
                ST_NUM: begin
                    if (w_cls == CL_DIGIT) begin
                        n_int = (r_int << 3) + (r_int << 1) + {28'd0, w_digit};
                    end else if (w_cls == CL_DOT) begin
                        n_frac = '0;
                        n_fc   = '0;
                    end
                end
                ST_FLT: begin
                    if (w_cls == CL_DIGIT && r_fc < FCW'(MAX_FRAC_DIGITS)) begin
                        n_frac = (r_frac << 3) + (r_frac << 1) + {26'd0, w_digit};
                        n_fc   = r_fc + 1'b1;
                    end
                end
                ST_NAME: begin
                    if ((w_cls == CL_DIGIT || w_cls == CL_ALPHA) &&
                        r_count < CW'(MAX_TEXT)) begin
                        o_wr_en = 1'b1;
                        n_count = w_app_idx + 1'b1;
                    end
                end
                ST_CMP: begin
                    if (w_cls == CL_EQ && r_count < CW'(MAX_TEXT)) begin
                        o_wr_en = 1'b1;
                        n_count = w_app_idx + 1'b1;
                    end
                end
                ST_COMM, ST_OP: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_wr_addr = {n_bank, w_app_row[RW-1:0]};
    assign o_wr_lane = w_app_idx[2:0];
    assign o_wr_data = i_char_code;

    // Token description, taken from the state before this byte acts.
    assign w_numeric = (r_state == ST_NUM) || (r_state == ST_FLT);
    assign w_fc_ext  = {4'd0, r_fc};

    always_comb begin
        o_desc_valid = w_byte && w_cur.none;
        unique case (r_state)
            ST_NUM:  o_desc.kind = KIND_INT;
            ST_FLT:  o_desc.kind = KIND_FLT;
            ST_NAME: o_desc.kind = KIND_NAME;
            default: o_desc.kind = KIND_OP;
        endcase
        o_desc.int_value    = w_numeric ? r_int : '0;
        o_desc.frac_digits  = (r_state == ST_FLT) ? r_frac : '0;
        o_desc.frac_count   = (r_state == ST_FLT) ? w_fc_ext[3:0] : '0;
        o_desc.start_line   = r_tline;
        o_desc.start_column = r_tcol;
        o_desc_count        = r_count;
        o_desc_bank         = r_bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_int   <= '0;
            r_frac  <= '0;
            r_fc    <= '0;
            r_count <= '0;
            r_line  <= 16'd1;
            r_col   <= '0;
            r_tline <= '0;
            r_tcol  <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_fc    <= n_fc;
            r_count <= n_count;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_bank  <= n_bank;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TEXT))
        else $error("text count beyond the text store");

endmodule

// ----- design/bst_emitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_emitter
// Holds one finished token, reads its text rows from the text store and
// drives the output register, one result transfer per cycle while not stalled.
// ----------------------------------------------------------------------------
module bst_emitter #(
    parameter int MAX_TEXT = 32,
    localparam int CW   = $clog2(MAX_TEXT + 1),
    localparam int ROWS = (MAX_TEXT + 7) / 8,
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int AW   = RW + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_desc_valid,
    input  bst_pkg::t_tok_info i_desc,
    input  logic [CW-1:0]      i_desc_count,
    input  logic               i_desc_bank,
    output logic               o_busy,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  logic [63:0]        i_rd_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_token_kind,
    output logic [31:0]        o_int_value,
    output logic [29:0]        o_frac_digits,
    output logic [3:0]         o_frac_count,
    output logic [63:0]        o_text_chunk,
    output logic [5:0]         o_text_length,
    output logic [15:0]        o_start_line,
    output logic [15:0]        o_start_column,
    output logic               o_last_chunk
);
    import bst_pkg::*;

    logic          r_slot_valid;
    t_tok_info     r_slot;
    logic [CW-1:0] r_slot_count;
    logic          r_slot_bank;
    logic [RW-1:0] r_k;

    logic          r_o_valid;
    t_tok_info     r_o;
    logic [5:0]    r_o_len;
    logic          r_o_last;
    logic [3:0]    r_o_nbytes;

    logic          w_numeric;
    logic          w_fire;
    logic          w_last;
    logic [CW-1:0] w_cm1;
    logic [CW-1:0] w_last_row;
    logic [CW+5:0] w_len_ext;
    logic [3:0]    w_nbytes;

    assign w_numeric  = (r_slot.kind == KIND_INT) || (r_slot.kind == KIND_FLT);
    assign w_fire     = r_slot_valid && (!r_o_valid || !i_stall);
    assign w_cm1      = r_slot_count - 1'b1;
    assign w_last_row = w_cm1 >> 3;
    assign w_last     = w_numeric || (r_k == w_last_row[RW-1:0]);
    assign w_len_ext  = {6'd0, r_slot_count};

    always_comb begin
        if (w_numeric) w_nbytes = 4'd0;
        else if (!w_last) w_nbytes = 4'd8;
        else w_nbytes = {1'b0, w_cm1[2:0]} + 4'd1;
    end

    assign o_busy    = r_slot_valid && !(w_fire && w_last);
    assign o_rd_en   = w_fire && !w_numeric;
    assign o_rd_addr = {r_slot_bank, r_k};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= 1'b0;
            r_k          <= '0;
        end else begin
            if (i_desc_valid) begin
                r_slot_valid <= 1'b1;
                r_k          <= '0;
            end else if (w_fire) begin
                if (w_last) r_slot_valid <= 1'b0;
                else r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_desc_valid) begin
            r_slot       <= i_desc;
            r_slot_count <= i_desc_count;
            r_slot_bank  <= i_desc_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_fire) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o        <= r_slot;
            r_o_len    <= w_numeric ? 6'd0 : w_len_ext[5:0];
            r_o_last   <= w_last;
            r_o_nbytes <= w_nbytes;
        end
    end

    // Bytes past the token's end read as zero.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            o_text_chunk[b*8 +: 8] = (4'(b) < r_o_nbytes) ? i_rd_data[b*8 +: 8] : 8'd0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_token_kind   = r_o.kind;
    assign o_int_value    = r_o.int_value;
    assign o_frac_digits  = r_o.frac_digits;
    assign o_frac_count   = r_o.frac_count;
    assign o_text_length  = r_o_len;
    assign o_start_line   = r_o.start_line;
    assign o_start_column = r_o.start_column;
    assign o_last_chunk   = r_o_last;

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_desc_valid |-> (!r_slot_valid || (w_fire && w_last)))
        else $error("token handed over while the slot still holds one");

    a_numeric_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o.kind == KIND_INT || r_o.kind == KIND_FLT))
            |-> (r_o_last && r_o_nbytes == 4'd0))
        else $error("numeric token not given as a single item");

endmodule

// ----- design/byte_stream_tokenizer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_tokenizer_unit
// Table-driven lexer that turns a source byte stream into integer, float,
// name and operator tokens with their start line and column.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ----------------------------------
//  input     in         i_valid / o_stall   i_char_code, i_end_of_input
//  result    out        o_valid / i_stall   token fields, one text chunk each
//
//  One byte is taken per cycle. A byte that closes a token hands the token to
//  the emitter slot in the same cycle; integers and floats leave as one result
//  transfer, names and operators as ceil(length/8) transfers, one per cycle
//  unless i_stall holds them, since the text store gives one eight-byte row
//  per read. A byte that closes a token is stalled only while the previous
//  token still holds the emitter slot. Reset is synchronous and active low;
//  the text store is not cleared and needs no clearing pass. Output stalls
//  back up into the input only through the emitter slot.
//
// The text store is split in two banks so that a finished token can be read
// out of one bank while the next token fills the other. Bank selection flips
// on every token handover.
module byte_stream_tokenizer_unit #(
    parameter int MAX_TEXT        = 32,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_token_kind,
    output logic [31:0] o_int_value,
    output logic [29:0] o_frac_digits,
    output logic [3:0]  o_frac_count,
    output logic [63:0] o_text_chunk,
    output logic [5:0]  o_text_length,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic        o_last_chunk
);
    import bst_pkg::*;

    localparam int CW   = $clog2(MAX_TEXT + 1);
    localparam int ROWS = (MAX_TEXT + 7) / 8;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW   = RW + 1;

    logic          w_busy;
    logic          w_desc_valid;
    t_tok_info     w_desc;
    logic [CW-1:0] w_desc_count;
    logic          w_desc_bank;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [2:0]    w_wr_lane;
    logic [7:0]    w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [63:0]   w_rd_data;

    // Scanner: classification, state table, accumulators and text writes.
    bst_lexer #(
        .MAX_TEXT        (MAX_TEXT),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_lexer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .i_busy         (w_busy),
        .o_stall        (o_stall),
        .o_desc_valid   (w_desc_valid),
        .o_desc         (w_desc),
        .o_desc_count   (w_desc_count),
        .o_desc_bank    (w_desc_bank),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_lane      (w_wr_lane),
        .o_wr_data      (w_wr_data)
    );

    // Two-bank text store, byte writes, row reads.
    bst_text_ram #(
        .AW (AW)
    ) u_text_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_lane (w_wr_lane),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Token slot and output register.
    bst_emitter #(
        .MAX_TEXT (MAX_TEXT)
    ) u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc_valid   (w_desc_valid),
        .i_desc         (w_desc),
        .i_desc_count   (w_desc_count),
        .i_desc_bank    (w_desc_bank),
        .o_busy         (w_busy),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_int_value    (o_int_value),
        .o_frac_digits  (o_frac_digits),
        .o_frac_count   (o_frac_count),
        .o_text_chunk   (o_text_chunk),
        .o_text_length  (o_text_length),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_last_chunk   (o_last_chunk)
    );

endmodule
